// ----- rtl/vpg_pkg.sv -----
// Shared types, constants and helpers for the point-gravity Verlet step pipeline.
`timescale 1ns / 1ps
`default_nettype none
package vpg_pkg;

   localparam int unsigned NUM_AXES  = 3;
   localparam int unsigned SQRT_BITS = 33;  // root of a 66-bit sum
   localparam int unsigned QBITS     = 40;  // quotient bits kept by the divider

   // pipeline stage numbers
   localparam int unsigned ST_MUL1  = 1;
   localparam int unsigned ST_HALF  = 2;
   localparam int unsigned ST_MUL2  = 3;
   localparam int unsigned ST_POS   = 4;
   localparam int unsigned ST_DIFF  = 5;
   localparam int unsigned ST_SQR   = 6;
   localparam int unsigned ST_SUM   = 7;
   localparam int unsigned ST_RT0   = 8;
   localparam int unsigned ST_CLAMP = ST_RT0 + SQRT_BITS;
   localparam int unsigned ST_DC2   = ST_CLAMP + 1;
   localparam int unsigned ST_PART  = ST_DC2 + 1;
   localparam int unsigned ST_DEN   = ST_PART + 1;
   localparam int unsigned ST_OVF   = ST_DEN + 1;
   localparam int unsigned ST_DV0   = ST_OVF + 1;
   localparam int unsigned ST_ACC   = ST_DV0 + QBITS;
   localparam int unsigned ST_ASUM  = ST_ACC + 1;
   localparam int unsigned ST_VMUL  = ST_ASUM + 1;
   localparam int unsigned ST_VEL   = ST_VMUL + 1;
   localparam int unsigned NS       = ST_VEL;

   typedef enum logic [2:0] {
      REG_ATT_X    = 3'd0,
      REG_ATT_Y    = 3'd1,
      REG_ATT_Z    = 3'd2,
      REG_GRAVITY  = 3'd3,
      REG_MIN_DIST = 3'd4
   } csr_reg_type;

   localparam logic [31:0] ATT_X_RST = 32'h0000_0000;
   localparam logic [31:0] ATT_Y_RST = 32'hFE70_0000;  // -400.0
   localparam logic [31:0] ATT_Z_RST = 32'h0000_0000;
   localparam logic [31:0] GRAV_RST  = 32'd7000000;
   localparam logic [30:0] MIND_RST  = 31'd327680;     // 5.0

   localparam logic [39:0] LIM_POS = 40'h7F_FFFF_FFFF;
   localparam logic [39:0] LIM_NEG = 40'h80_0000_0000;

   // sideband that travels with each particle; fields fill in as stages finish
   typedef struct packed {
      logic [2:0][31:0] pos;   // new position from ST_POS on
      logic [2:0][31:0] vel;
      logic [2:0][39:0] acc;
      logic [16:0]      dt;
      logic [2:0][32:0] mag;   // |attractor - new position|
      logic [2:0]       neg;
      logic             zero;
      logic [32:0]      rdist;
      logic [32:0]      dc;
      logic [2:0][64:0] gm;
      logic [98:0]      den;
      logic [2:0]       ovf;
      logic [2:0][39:0] nacc;
   } carry_type;

   function automatic logic signed [17:0] dt_ext(input logic [16:0] dt);
      return $signed({1'b0, dt});
   endfunction

   function automatic logic [31:0] sat32(input logic signed [63:0] x);
      if (x > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
      else if (x < -64'sh8000_0000) return 32'h8000_0000;
      else return x[31:0];
   endfunction

endpackage
`default_nettype wire

// ----- rtl/verlet_point_gravity_step.sv -----
// Top level: fully pipelined velocity-Verlet step with inverse-square pull to an attractor.
//
// Takes one particle word per clock and returns one result word per clock while the
// output is not stalled. Pipeline depth is set by the 33-stage bit-per-stage
// square-root pipeline and the 40-stage bit-per-stage divider (one per axis) that
// forms g*|d|/(dist*dc^2). Each stage holds its word while the next one is full and
// stalled, so bubbles close up and nothing is lost. Configuration registers may be
// written only while no particle is in flight; csr_ready is always high.
`timescale 1ns / 1ps
`default_nettype none
module verlet_point_gravity_step
   import vpg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z, time_step, 7 zero bits
   input  logic [335:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // new_pos_x/y/z, new_vel_x/y/z, new_acc_x/y/z
   output logic [311:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);

   // ---------------- configuration ----------------
   logic signed [31:0] att_ff [NUM_AXES];
   logic [31:0]        grav_ff;
   logic [30:0]        mind_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         att_ff[0] <= ATT_X_RST;
         att_ff[1] <= ATT_Y_RST;
         att_ff[2] <= ATT_Z_RST;
         grav_ff   <= GRAV_RST;
         mind_ff   <= MIND_RST;
      end else if (csr_valid) begin
         unique case (csr_reg_type'(csr_index))
            REG_ATT_X:    att_ff[0] <= csr_data;
            REG_ATT_Y:    att_ff[1] <= csr_data;
            REG_ATT_Z:    att_ff[2] <= csr_data;
            REG_GRAVITY:  grav_ff   <= csr_data;
            REG_MIN_DIST: mind_ff   <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   // ---------------- pipeline control ----------------
   logic vld_ff [1:NS];
   logic en     [1:NS+1];

   always_comb begin
      en[NS+1] = rsp_tready;
      for (int k = NS; k >= 1; k--) en[k] = !vld_ff[k] || en[k+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= NS; k++) vld_ff[k] <= 1'b0;
      end else begin
         if (en[1]) vld_ff[1] <= req_tvalid;
         for (int k = 2; k <= NS; k++) if (en[k]) vld_ff[k] <= vld_ff[k-1];
      end
   end

   assign req_tready = en[1];
   assign rsp_tvalid = vld_ff[NS];

   // ---------------- sideband ----------------
   carry_type car_ff [1:NS];
   carry_type car_in [1:NS];

   logic [2:0][31:0] np_w;
   logic [2:0][32:0] mag_w;
   logic [2:0]       neg_w;
   logic [65:0]      s_in;
   logic [32:0]      dist_w, dc_w;
   logic [2:0][64:0] gm_w;
   logic [98:0]      den_w;
   logic [2:0]       ovf_w;
   logic [2:0][39:0] nacc_w;

   always_comb begin
      car_in[1] = '0;
      for (int i = 0; i < NUM_AXES; i++) begin
         car_in[1].pos[i] = req_tdata[32*i +: 32];
         car_in[1].vel[i] = req_tdata[96 + 32*i +: 32];
         car_in[1].acc[i] = req_tdata[192 + 40*i +: 40];
      end
      car_in[1].dt = req_tdata[328:312];
      for (int k = 2; k <= NS; k++) car_in[k] = car_ff[k-1];
      car_in[ST_POS].pos     = np_w;
      car_in[ST_DIFF].mag    = mag_w;
      car_in[ST_DIFF].neg    = neg_w;
      car_in[ST_SUM].zero    = (s_in == '0);
      car_in[ST_CLAMP].rdist = dist_w;
      car_in[ST_CLAMP].dc    = dc_w;
      car_in[ST_CLAMP].gm    = gm_w;
      car_in[ST_DEN].den     = den_w;
      car_in[ST_OVF].ovf     = ovf_w;
      car_in[ST_ACC].nacc    = nacc_w;
   end

   always_ff @(posedge clock) begin
      for (int k = 1; k <= NS; k++) if (en[k]) car_ff[k] <= car_in[k];
   end

   // ---------------- position update ----------------
   logic signed [57:0] ad_ff  [NUM_AXES], ad_in  [NUM_AXES];
   logic signed [49:0] vd_ff  [NUM_AXES], vd_in  [NUM_AXES];
   logic signed [41:0] h_ff   [NUM_AXES], h_in   [NUM_AXES];
   logic signed [49:0] vd2_ff [NUM_AXES];
   logic signed [59:0] hd_ff  [NUM_AXES], hd_in  [NUM_AXES];
   logic signed [49:0] vd3_ff [NUM_AXES];
   logic signed [57:0] hsum;
   logic signed [60:0] psum;
   logic signed [43:0] pq;

   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         ad_in[i] = $signed(car_in[1].acc[i]) * dt_ext(car_in[1].dt);
         vd_in[i] = $signed(car_in[1].vel[i]) * dt_ext(car_in[1].dt);
      end
   end

   always_comb begin
      hsum = '0;
      for (int i = 0; i < NUM_AXES; i++) begin
         hsum    = ad_ff[i] + 58'sh8000;
         h_in[i] = hsum[57:16];
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_AXES; i++)
         hd_in[i] = h_ff[i] * dt_ext(car_ff[ST_MUL2-1].dt);
   end

   // p + round((2*v*dt + h*dt) / 2^17)
   always_comb begin
      psum = '0;
      pq   = '0;
      for (int i = 0; i < NUM_AXES; i++) begin
         psum    = (61'(vd3_ff[i]) <<< 1) + 61'(hd_ff[i]) + 61'sh10000;
         pq      = psum[60:17];
         np_w[i] = sat32(64'(pq) + 64'($signed(car_ff[ST_POS-1].pos[i])));
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_MUL1]) begin
         ad_ff <= ad_in;
         vd_ff <= vd_in;
      end
      if (en[ST_HALF]) begin
         h_ff   <= h_in;
         vd2_ff <= vd_ff;
      end
      if (en[ST_MUL2]) begin
         hd_ff  <= hd_in;
         vd3_ff <= vd2_ff;
      end
   end

   // ---------------- distance ----------------
   logic signed [32:0] dw;
   logic [65:0]        sq_ff [NUM_AXES], sq_in [NUM_AXES];
   logic [65:0]        s_ff;

   always_comb begin
      dw = '0;
      for (int i = 0; i < NUM_AXES; i++) begin
         dw       = 33'(att_ff[i]) - 33'($signed(car_ff[ST_DIFF-1].pos[i]));
         neg_w[i] = dw[32];
         mag_w[i] = dw[32] ? 33'(-dw) : 33'(dw);
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_AXES; i++)
         sq_in[i] = 66'(car_ff[ST_SQR-1].mag[i]) * 66'(car_ff[ST_SQR-1].mag[i]);
      s_in = sq_ff[0] + sq_ff[1] + sq_ff[2];
   end

   always_ff @(posedge clock) begin
      if (en[ST_SQR]) sq_ff <= sq_in;
      if (en[ST_SUM]) s_ff  <= s_in;
   end

   // one root bit per stage: accept bit if (r + 2^b)^2 - r^2 fits in the remainder
   logic [32:0] rt_root_ff [0:SQRT_BITS-1];
   logic [65:0] rt_rem_ff  [0:SQRT_BITS-1];

   for (genvar j = 0; j < SQRT_BITS; j++) begin : g_rt
      localparam int B = SQRT_BITS - 1 - j;
      logic [32:0] root_prev, root_in;
      logic [65:0] rem_prev, rem_in;
      logic [67:0] trial;

      if (j == 0) begin : g_first
         assign root_prev = '0;
         assign rem_prev  = s_ff;
      end else begin : g_next
         assign root_prev = rt_root_ff[j-1];
         assign rem_prev  = rt_rem_ff[j-1];
      end

      always_comb begin
         trial = (68'(root_prev) << (B + 1)) + (68'd1 << (2 * B));
         if (trial <= 68'(rem_prev)) begin
            root_in = root_prev | (33'd1 << B);
            rem_in  = rem_prev - trial[65:0];
         end else begin
            root_in = root_prev;
            rem_in  = rem_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en[ST_RT0+j]) begin
            rt_root_ff[j] <= root_in;
            rt_rem_ff[j]  <= rem_in;
         end
      end
   end

   // ---------------- denominator dist * dc^2 ----------------
   logic [65:0] dc2_ff;
   logic [65:0] plo_ff, phi_ff;

   always_comb begin
      dist_w = rt_root_ff[SQRT_BITS-1];
      dc_w   = (dist_w > {2'b00, mind_ff}) ? dist_w : {2'b00, mind_ff};
      for (int i = 0; i < NUM_AXES; i++)
         gm_w[i] = 65'(grav_ff) * 65'(car_ff[ST_CLAMP-1].mag[i]);
      den_w = 99'(plo_ff) + (99'(phi_ff) << 33);
   end

   always_ff @(posedge clock) begin
      if (en[ST_DC2]) dc2_ff <= 66'(car_ff[ST_DC2-1].dc) * 66'(car_ff[ST_DC2-1].dc);
      if (en[ST_PART]) begin
         plo_ff <= 66'(dc2_ff[32:0])  * 66'(car_ff[ST_PART-1].rdist);
         phi_ff <= 66'(dc2_ff[65:33]) * 66'(car_ff[ST_PART-1].rdist);
      end
   end

   // ---------------- divide g*|d|*2^48 by the denominator ----------------
   // quotient >= 2^40 saturates anyway, so only its low 40 bits are developed
   logic [98:0] dv_top_ff [NUM_AXES], dv_top_in [NUM_AXES];
   logic [72:0] numhi;

   always_comb begin
      numhi = '0;
      for (int i = 0; i < NUM_AXES; i++) begin
         numhi        = {car_ff[ST_OVF-1].gm[i], 8'h00};
         ovf_w[i]     = (99'(numhi) >= car_ff[ST_OVF-1].den);
         dv_top_in[i] = ovf_w[i] ? '0 : 99'(numhi);
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_OVF]) dv_top_ff <= dv_top_in;
   end

   logic [98:0] dv_rem_ff [0:QBITS-1][NUM_AXES];
   logic [39:0] dv_q_ff   [0:QBITS-1][NUM_AXES];

   for (genvar j = 0; j < QBITS; j++) begin : g_dv
      logic [98:0] rem_prev [NUM_AXES];
      logic [39:0] q_prev   [NUM_AXES];
      logic [98:0] rem_in   [NUM_AXES];
      logic [39:0] q_in     [NUM_AXES];
      logic [99:0] rsh, rdif;
      logic [98:0] den;

      if (j == 0) begin : g_first
         always_comb begin
            for (int i = 0; i < NUM_AXES; i++) begin
               rem_prev[i] = dv_top_ff[i];
               q_prev[i]   = '0;
            end
         end
      end else begin : g_next
         always_comb begin
            for (int i = 0; i < NUM_AXES; i++) begin
               rem_prev[i] = dv_rem_ff[j-1][i];
               q_prev[i]   = dv_q_ff[j-1][i];
            end
         end
      end

      always_comb begin
         den  = car_ff[ST_DV0+j-1].den;
         rsh  = '0;
         rdif = '0;
         for (int i = 0; i < NUM_AXES; i++) begin
            rsh  = {rem_prev[i], 1'b0};
            rdif = rsh - {1'b0, den};
            if (rsh >= {1'b0, den}) begin
               rem_in[i] = rdif[98:0];
               q_in[i]   = {q_prev[i][38:0], 1'b1};
            end else begin
               rem_in[i] = rsh[98:0];
               q_in[i]   = {q_prev[i][38:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en[ST_DV0+j]) begin
            dv_rem_ff[j] <= rem_in;
            dv_q_ff[j]   <= q_in;
         end
      end
   end

   // ---------------- new acceleration and velocity ----------------
   logic [39:0] lim, qv, mg;

   always_comb begin
      lim = '0;
      qv  = '0;
      mg  = '0;
      for (int i = 0; i < NUM_AXES; i++) begin
         qv  = dv_q_ff[QBITS-1][i];
         lim = car_ff[ST_ACC-1].neg[i] ? LIM_NEG : LIM_POS;
         mg  = (car_ff[ST_ACC-1].ovf[i] || qv > lim) ? lim : qv;
         if (car_ff[ST_ACC-1].zero) nacc_w[i] = '0;
         else nacc_w[i] = car_ff[ST_ACC-1].neg[i] ? -mg : mg;
      end
   end

   logic signed [40:0] asum_ff [NUM_AXES];
   logic signed [58:0] vm_ff   [NUM_AXES];
   logic [31:0]        nv_ff   [NUM_AXES], nv_in [NUM_AXES];
   logic signed [58:0] vsum;
   logic signed [41:0] vq;

   always_comb begin
      vsum = '0;
      vq   = '0;
      for (int i = 0; i < NUM_AXES; i++) begin
         vsum     = vm_ff[i] + 59'sh10000;
         vq       = vsum[58:17];
         nv_in[i] = sat32(64'(vq) + 64'($signed(car_ff[ST_VEL-1].vel[i])));
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_AXES; i++) begin
         if (en[ST_ASUM])
            asum_ff[i] <= 41'($signed(car_ff[ST_ASUM-1].acc[i]))
                        + 41'($signed(car_ff[ST_ASUM-1].nacc[i]));
         if (en[ST_VMUL])
            vm_ff[i] <= asum_ff[i] * dt_ext(car_ff[ST_VMUL-1].dt);
      end
      if (en[ST_VEL]) nv_ff <= nv_in;
   end

   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         rsp_tdata[32*i +: 32]       = car_ff[NS].pos[i];
         rsp_tdata[96 + 32*i +: 32]  = nv_ff[i];
         rsp_tdata[192 + 40*i +: 40] = car_ff[NS].nacc[i];
      end
   end

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Testbench for the point-gravity Verlet step: directed table, random particles, self-checking.
`timescale 1ns / 1ps
module tb;
   import vpg_pkg::*;

   typedef struct {
      logic [31:0] pos [3];
      logic [31:0] vel [3];
      logic [39:0] acc [3];
      logic [16:0] dt;
   } particle_type;

   typedef struct {
      logic [31:0] pos [3];
      logic [31:0] vel [3];
      logic [39:0] acc [3];
   } step_type;

   // directed row: particle, and optionally a typed-in expected step
   typedef struct {
      particle_type p;
      bit           has_exp;
      step_type     e;
   } row_type;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [335:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [311:0] rsp_tdata;
   logic         csr_valid = 0;
   logic         csr_ready;
   logic [2:0]   csr_index = '0;
   logic [31:0]  csr_data = '0;

   verlet_point_gravity_step dut (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   initial begin
      #20000000;
      $display("tb: failure");
      $finish;
   end

   // predictor's copy of the registers
   logic signed [31:0] att [3];
   logic [31:0]        grav;
   logic [30:0]        min_dist;

   step_type step_q [$];
   int     mismatches = 0;
   bit     idle_en = 1;
   bit     hold_off = 0;
   int     accepted = 0;

   function automatic logic signed [127:0] rnd_half_up(logic signed [127:0] x, int n);
      return (x + (128'sd1 <<< (n - 1))) >>> n;
   endfunction

   function automatic logic [31:0] clip32(logic signed [127:0] x);
      if (x > 128'sh7FFF_FFFF) return 32'h7FFF_FFFF;
      if (x < -128'sh8000_0000) return 32'h8000_0000;
      return x[31:0];
   endfunction

   function automatic step_type verlet_step(particle_type p);
      step_type r;
      logic signed [127:0] a [3], v [3], d [3], h, np, dt;
      logic [127:0] s, rdist, dc, den, m, q, lim, c;
      dt = {111'd0, p.dt};
      s = 0;
      for (int i = 0; i < 3; i++) begin
         v[i] = $signed(p.vel[i]);
         a[i] = $signed(p.acc[i]);
         h = rnd_half_up(a[i] * dt, 16);
         np = $signed(p.pos[i]) + rnd_half_up(2 * v[i] * dt + h * dt, 17);
         r.pos[i] = clip32(np);
         d[i] = att[i] - $signed(r.pos[i]);
         m = d[i] < 0 ? -d[i] : d[i];
         s += m * m;
      end
      if (s == 0) begin
         for (int i = 0; i < 3; i++) r.acc[i] = '0;
      end else begin
         rdist = 0;
         for (int b = 35; b >= 0; b--) begin
            c = rdist | (128'd1 << b);
            if (c * c <= s) rdist = c;
         end
         dc = rdist > min_dist ? rdist : {97'd0, min_dist};
         den = dc * dc * rdist;
         for (int i = 0; i < 3; i++) begin
            m = d[i] < 0 ? -d[i] : d[i];
            q = ((grav * m) << 48) / den;
            lim = d[i] < 0 ? (128'd1 << 39) : (128'd1 << 39) - 1;
            if (q > lim) q = lim;
            r.acc[i] = d[i] < 0 ? -q[39:0] : q[39:0];
         end
      end
      for (int i = 0; i < 3; i++)
         r.vel[i] = clip32(v[i] + rnd_half_up((a[i] + $signed(r.acc[i])) * dt, 17));
      return r;
   endfunction

   function automatic logic [335:0] pack_particle(particle_type p);
      return {7'd0, p.dt, p.acc[2], p.acc[1], p.acc[0], p.vel[2], p.vel[1], p.vel[0],
              p.pos[2], p.pos[1], p.pos[0]};
   endfunction

   function automatic particle_type rand_particle(int mode);
      particle_type p;
      for (int i = 0; i < 3; i++) begin
         if (mode == 0) begin
            // full-range noise
            p.pos[i] = $urandom;
            p.vel[i] = $urandom;
            p.acc[i] = 40'({$urandom, $urandom});
         end else begin
            // moderate orbit-like values near the attractor
            p.pos[i] = att[i] + $signed($urandom_range(0, 2 ** 26) - 2 ** 25);
            p.vel[i] = $signed($urandom_range(0, 2 ** 24) - 2 ** 23);
            p.acc[i] = $signed(40'($urandom_range(0, 2 ** 28)) - 40'(2 ** 27));
         end
      end
      p.dt = ($urandom_range(0, 3) == 0) ? 17'($urandom) : 17'($urandom_range(0, 2200));
      return p;
   endfunction

   task automatic csr_write(csr_reg_type idx, logic [31:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 0;
      case (idx)
         REG_ATT_X: att[0] = val;
         REG_ATT_Y: att[1] = val;
         REG_ATT_Z: att[2] = val;
         REG_GRAVITY: grav = val;
         REG_MIN_DIST: min_dist = val[30:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (step_q.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   // offers one particle; expected step either typed in or predicted
   task automatic send(particle_type p, bit has_exp, step_type e);
      if (idle_en && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= pack_particle(p);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      step_q.insert(step_q.size(), has_exp ? e : verlet_step(p));
      accepted++;
      @(negedge clock);
   endtask

   // receiver side
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off) rsp_tready <= 0;
         else if (idle_en && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 0;
            repeat ($urandom_range(1, 10)) @(negedge clock);
            rsp_tready <= !hold_off;
         end else rsp_tready <= 1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         step_type e;
         logic [311:0] exp_w;
         if (step_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %h", rsp_tdata);
         end else begin
            e = step_q.pop_front();
            exp_w = {e.acc[2], e.acc[1], e.acc[0], e.vel[2], e.vel[1], e.vel[0],
                     e.pos[2], e.pos[1], e.pos[0]};
            if (exp_w !== rsp_tdata) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch exp %h got %h", exp_w, rsp_tdata);
            end
         end
      end
   end

   initial begin
      row_type rows [$];
      row_type r;
      step_type none;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      att[0] = ATT_X_RST; att[1] = ATT_Y_RST; att[2] = ATT_Z_RST;
      grav = GRAV_RST; min_dist = MIND_RST;

      // particle sitting on the default attractor, zero step: passes, no pull
      r = '{default: '0};
      r.p.pos[1] = ATT_Y_RST;
      r.p.vel[0] = 32'h0001_0000;
      r.p.acc[2] = 40'h00_0005_0000;
      r.has_exp = 1;
      r.e.pos = r.p.pos; r.e.vel = r.p.vel; r.e.acc = '{default: '0};
      rows.insert(rows.size(), r);
      // field extremes
      for (int k = 0; k < 4; k++) begin
         r = '{default: '0};
         for (int i = 0; i < 3; i++) begin
            r.p.pos[i] = k[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
            r.p.vel[i] = k[1] ? 32'h7FFF_FFFF : 32'h8000_0000;
            r.p.acc[i] = k[0] ? LIM_POS : LIM_NEG;
         end
         r.p.dt = k[1] ? 17'h1_FFFF : 17'h0_0001;
         rows.insert(rows.size(), r);
      end
      // one raw unit from the attractor, unit step
      r = '{default: '0};
      r.p.pos[1] = ATT_Y_RST + 1;
      r.p.dt = 17'h1_0000;
      rows.insert(rows.size(), r);
      r.p.pos[1] = ATT_Y_RST - 32'h0010_0000;
      rows.insert(rows.size(), r);
      foreach (rows[i]) send(rows[i].p, rows[i].has_exp, rows[i].e);
      drain();

      // zero gravity and zero clamp, extremes of the registers
      csr_write(REG_GRAVITY, 32'd0);
      csr_write(REG_MIN_DIST, 32'd0);
      csr_write(REG_ATT_X, 32'h7FFF_FFFF);
      csr_write(REG_ATT_Y, 32'h8000_0000);
      csr_write(REG_ATT_Z, 32'h0000_0000);
      for (int n = 0; n < 10; n++) send(rand_particle(n % 2), 0, none);
      r = '{default: '0};
      r.p.pos[0] = 32'h7FFF_FFFF; r.p.pos[1] = 32'h8000_0000;
      send(r.p, 0, none);
      drain();
      csr_write(REG_GRAVITY, 32'hFFFF_FFFF);
      csr_write(REG_MIN_DIST, 32'hFFFF_FFFF);
      for (int n = 0; n < 10; n++) send(rand_particle(n % 2), 0, none);
      drain();

      // random phases with varied register settings
      for (int ph = 0; ph < 6; ph++) begin
         csr_write(REG_ATT_X, $urandom_range(0, 2 ** 28) - 2 ** 27);
         csr_write(REG_ATT_Y, ph == 0 ? ATT_Y_RST : $urandom);
         csr_write(REG_ATT_Z, $urandom_range(0, 2 ** 28) - 2 ** 27);
         csr_write(REG_GRAVITY, ph == 1 ? GRAV_RST : $urandom);
         csr_write(REG_MIN_DIST, ph == 2 ? 32'd0 : $urandom_range(0, 2 ** 22));
         if (ph == 3) idle_en = 0;
         for (int n = 0; n < 95; n++) send(rand_particle($urandom_range(0, 4) != 0), 0, none);
         if (ph == 1) begin
            // long receiver stall while particles keep coming
            fork
               begin
                  hold_off = 1;
                  repeat (300) @(negedge clock);
                  hold_off = 0;
               end
               for (int n = 0; n < 130; n++) send(rand_particle(1), 0, none);
            join
         end
         drain();
      end

      if (mismatches == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end
endmodule
